// ===== rtl/core/ufds_pkg.sv =====
// Shared constants, types and codes for the union-find block.
package ufds_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ELEM_W       = 11;
    localparam int SIZE_W       = 11;
    localparam int CFG_DW       = 32;
    localparam int CFG_AW       = 3;

    localparam logic [ELEM_W-1:0] ELEM_MAX    = ELEM_W'(MAX_ELEMENTS);
    localparam logic [ELEM_W-1:0] COUNT_RESET =
        ELEM_W'((1024 > MAX_ELEMENTS) ? MAX_ELEMENTS : 1024);

    typedef logic [ELEM_W-1:0] t_elem;
    typedef logic [SIZE_W-1:0] t_size;

    localparam logic [1:0] ACT_FIND = 2'd0;
    localparam logic [1:0] ACT_SAME = 2'd1;
    localparam logic [1:0] ACT_JOIN = 2'd2;

    localparam logic CFG_REG_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_COMP,
        S_SIZE_A,
        S_SIZE_B,
        S_DONE
    } t_state;

    typedef struct packed {
        t_elem rd_addr;
        logic  wr_en;
        t_elem wr_addr;
        t_elem wr_data;
    } t_par_req;

    typedef struct packed {
        t_elem rd_addr;
        logic  wr_en;
        t_elem wr_addr;
        t_size wr_data;
    } t_size_req;

    typedef struct packed {
        t_elem root_first;
        t_elem root_second;
        logic  in_one_set;
        logic  merged;
        logic  index_error;
    } t_result;

endpackage

// ===== rtl/core/ufds_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface ufds_in_if import ufds_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] action;
    t_elem      first_element;
    t_elem      second_element;

    modport source(output valid, action, first_element, second_element, input ready);
    modport sink(input valid, action, first_element, second_element, output ready);
endinterface

interface ufds_out_if import ufds_pkg::*; ();
    logic  valid;
    logic  ready;
    t_elem root_first;
    t_elem root_second;
    logic  in_one_set;
    logic  merged;
    logic  index_error;

    modport source(output valid, root_first, root_second, in_one_set, merged, index_error,
                   input ready);
    modport sink(input valid, root_first, root_second, in_one_set, merged, index_error,
                 output ready);
endinterface

// ===== rtl/core/ufds_tables.sv =====
// Parent and set-size memories with the singleton clearing sweep.
module ufds_tables
    import ufds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_clear,
    output logic      o_busy,
    input  t_par_req  i_par,
    output t_elem     o_par_rdata,
    input  t_size_req i_size,
    output t_size     o_size_rdata
);

    t_elem par_mem  [MAX_ELEMENTS+1];
    t_size size_mem [MAX_ELEMENTS+1];

    logic  r_clr_active;
    t_elem r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (i_clear) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            if (r_clr_idx == ELEM_MAX) begin
                r_clr_active <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + ELEM_W'(1);
        end
    end

    assign o_busy = r_clr_active;

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            par_mem[r_clr_idx] <= r_clr_idx;
        end else if (i_par.wr_en) begin
            par_mem[i_par.wr_addr] <= i_par.wr_data;
        end
        o_par_rdata <= par_mem[i_par.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            size_mem[r_clr_idx] <= SIZE_W'(1);
        end else if (i_size.wr_en) begin
            size_mem[i_size.wr_addr] <= i_size.wr_data;
        end
        o_size_rdata <= size_mem[i_size.rd_addr];
    end

endmodule

// ===== rtl/core/union_find_disjoint_sets.sv =====
// Top level: disjoint-set forest with path compression and union by size.
//
// Requests arrive on i_req (valid/ready); one transfer carries action, first_element
// and second_element. Each request yields exactly one result on o_rsp (valid/ready).
// Find walks parent links to the root, then walks the path again, rewriting each link
// to the root. Test and join do this for both elements; a join that combines two sets
// then reads both set sizes and writes the new size and link. All walks share the
// parent memory's single read port.
// The result becomes valid at the edge that returns the sequencer to idle; one request
// is in flight at a time, and i_req.ready is high only while the sequencer is idle.
// Out-of-range indices and the unused action code go from idle straight to S_DONE.
// Results sit in an output register, so a stalled receiver does not stop the next
// request from being taken; it only holds the sequencer at its final step.
// After reset, and after every write of element_count, a sweep over all MAX_ELEMENTS + 1
// table entries makes every element a singleton; no request is taken during it.
// Configuration: element_count at byte address 0 (0 reads as 1, large values saturate).
module union_find_disjoint_sets
    import ufds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ufds_in_if.sink           i_req,
    ufds_out_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_state    r_state, n_state;
    logic [1:0] r_act, n_act;
    t_elem     r_a, n_a, r_b, n_b, r_cur, n_cur, r_ra, n_ra, r_rb, n_rb;
    t_size     r_sa, n_sa;
    logic      r_second, n_second, r_same, n_same, r_merged, n_merged, r_err, n_err;
    t_elem     r_count;
    logic      r_out_valid;
    t_result   r_out;

    t_par_req  par_req;
    t_size_req size_req;
    t_elem     par_rdata;
    t_size     size_rdata;
    logic      tbl_busy;

    logic      cfg_wr, accept, out_free, a_ok, b_ok, in_err, root_hit, at_root, do_join;
    t_elem     cur_root, cfg_val, big_root, small_root;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == CFG_REG_COUNT);
    assign prdata  = CFG_DW'(r_count);
    assign cfg_val = pwdata[ELEM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            if (cfg_val == '0) begin
                r_count <= ELEM_W'(1);
            end else if (cfg_val > ELEM_MAX) begin
                r_count <= ELEM_MAX;
            end else begin
                r_count <= cfg_val;
            end
        end
    end

    ufds_tables u_tables (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_wr),
        .o_busy       (tbl_busy),
        .i_par        (par_req),
        .o_par_rdata  (par_rdata),
        .i_size       (size_req),
        .o_size_rdata (size_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE) && !tbl_busy;
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign a_ok   = (i_req.first_element != '0) && (i_req.first_element <= r_count);
    assign b_ok   = (i_req.second_element != '0) && (i_req.second_element <= r_count);
    assign in_err = (i_req.action == ACT_FIND) ? !a_ok : !(a_ok && b_ok);

    assign root_hit = (par_rdata == r_cur);
    assign cur_root = r_second ? r_rb : r_ra;
    assign at_root  = (r_cur == cur_root);
    assign do_join  = (r_act == ACT_JOIN) && (r_ra != r_rb);

    // Single comparator picks the larger set; the first root wins a tie
    assign big_root   = (r_sa < size_rdata) ? r_rb : r_ra;
    assign small_root = (r_sa < size_rdata) ? r_ra : r_rb;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_req.action == ACT_FIND || i_req.action == ACT_SAME ||
                         i_req.action == ACT_JOIN) && !in_err) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (root_hit) begin
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                if (at_root) begin
                    if (!r_second) begin
                        n_state = (r_act == ACT_FIND) ? S_DONE : S_WALK;
                    end else begin
                        n_state = do_join ? S_SIZE_A : S_DONE;
                    end
                end
            end
            S_SIZE_A: n_state = S_SIZE_B;
            S_SIZE_B: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_act    = r_act;
        n_a      = r_a;
        n_b      = r_b;
        n_cur    = r_cur;
        n_ra     = r_ra;
        n_rb     = r_rb;
        n_sa     = r_sa;
        n_second = r_second;
        n_same   = r_same;
        n_merged = r_merged;
        n_err    = r_err;
        par_req.rd_addr  = r_cur;
        par_req.wr_en    = 1'b0;
        par_req.wr_addr  = r_cur;
        par_req.wr_data  = cur_root;
        size_req.rd_addr = r_ra;
        size_req.wr_en   = 1'b0;
        size_req.wr_addr = big_root;
        size_req.wr_data = r_sa + size_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act    = i_req.action;
                    n_a      = i_req.first_element;
                    n_b      = i_req.second_element;
                    n_cur    = i_req.first_element;
                    n_ra     = '0;
                    n_rb     = '0;
                    n_second = 1'b0;
                    n_same   = 1'b0;
                    n_merged = 1'b0;
                    n_err    = (i_req.action == ACT_FIND || i_req.action == ACT_SAME ||
                                i_req.action == ACT_JOIN) && in_err;
                    par_req.rd_addr = i_req.first_element;
                end
            end
            S_WALK: begin
                if (root_hit) begin
                    if (r_second) begin
                        n_rb = r_cur;
                    end else begin
                        n_ra = r_cur;
                    end
                    n_cur           = r_second ? r_b : r_a;
                    par_req.rd_addr = r_second ? r_b : r_a;
                end else begin
                    n_cur           = par_rdata;
                    par_req.rd_addr = par_rdata;
                end
            end
            S_COMP: begin
                if (at_root) begin
                    if (!r_second) begin
                        n_second        = 1'b1;
                        n_cur           = r_b;
                        par_req.rd_addr = r_b;
                    end else begin
                        n_same           = (r_ra == r_rb);
                        size_req.rd_addr = r_ra;
                    end
                end else begin
                    par_req.wr_en   = 1'b1;
                    n_cur           = par_rdata;
                    par_req.rd_addr = par_rdata;
                end
            end
            S_SIZE_A: begin
                n_sa             = size_rdata;
                size_req.rd_addr = r_rb;
            end
            S_SIZE_B: begin
                size_req.wr_en  = 1'b1;
                par_req.wr_en   = 1'b1;
                par_req.wr_addr = small_root;
                par_req.wr_data = big_root;
                n_merged        = 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_a      <= n_a;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_sa     <= n_sa;
        r_second <= n_second;
        r_same   <= n_same;
        r_merged <= n_merged;
        r_err    <= n_err;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.root_first  <= r_ra;
            r_out.root_second <= r_rb;
            r_out.in_one_set  <= r_same;
            r_out.merged      <= r_merged;
            r_out.index_error <= r_err;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.root_first  = r_out.root_first;
    assign o_rsp.root_second = r_out.root_second;
    assign o_rsp.in_one_set  = r_out.in_one_set;
    assign o_rsp.merged      = r_out.merged;
    assign o_rsp.index_error = r_out.index_error;

    a_no_take_while_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_busy |-> !i_req.ready)
        else $error("request taken during clearing sweep");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after a transfer");

    a_cfg_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> tbl_busy)
        else $error("count write did not start clearing sweep");

    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.merged |-> !o_rsp.in_one_set && !o_rsp.index_error &&
            (o_rsp.root_first != o_rsp.root_second))
        else $error("merge reported on one set");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.index_error |-> !o_rsp.merged && !o_rsp.in_one_set &&
            (o_rsp.root_first == '0))
        else $error("error result carries data");

endmodule
